@@ rtl/sfe_pkg.sv @@
// Package for the serial frame encoder: phase codes, CRC control struct,
// configuration indexes and the CRC-8/CRC-16 byte update functions.
// No dependencies.
package sfe_pkg;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOF = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD = 1'd1;

    localparam logic [7:0]  SOF_RESET   = 8'hA5;
    localparam logic [15:0] CMD_RESET   = 16'h0301;
    localparam logic [7:0]  CRC8_INIT   = 8'hFF;
    localparam logic [15:0] CRC16_INIT  = 16'hFFFF;
    localparam logic [7:0]  CRC8_POLY   = 8'h8C;
    localparam logic [15:0] CRC16_POLY  = 16'h8408;

    typedef enum logic [9:0] {
        PH_SOF    = 10'b00_0000_0001,
        PH_LEN_LO = 10'b00_0000_0010,
        PH_LEN_HI = 10'b00_0000_0100,
        PH_SEQ    = 10'b00_0000_1000,
        PH_CRC8   = 10'b00_0001_0000,
        PH_CMD_LO = 10'b00_0010_0000,
        PH_CMD_HI = 10'b00_0100_0000,
        PH_DATA   = 10'b00_1000_0000,
        PH_CRC_LO = 10'b01_0000_0000,
        PH_CRC_HI = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic fold16;   // fold emitted byte into CRC-16
        logic fold8;    // fold emitted byte into CRC-8
        logic restart;  // start both CRCs from init
        logic clear16;  // trailer done, CRC-16 back to init
    } t_crc_ctl;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/serial_frame_encoder_crc8_crc16.sv @@
// Serial frame encoder: header with CRC-8, command id, payload, CRC-16 trailer.
// Throughput: one output byte per cycle while m_axis_tready allows it, set by the single output register;
// a plain payload word gives 1 byte, a first word 8, a last word 3, both 10.
// Reset (synchronous, active low): sequence number 0, CRC-16 0xFFFF, defaults
// 0xA5 / 0x0301 in the config registers, both channels empty.
module serial_frame_encoder_crc8_crc16 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                  i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [23:0]                  s_axis_tdata,  // [7:0] payload_byte, [23:8] payload_length
    input  logic                         s_axis_tlast,  // last_byte
    input  logic                         s_axis_tuser,  // first_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,  // [7:0] tx_byte
    output logic                         m_axis_tlast   // run_end
);
    import sfe_pkg::*;

    logic [7:0]  r_sof, r_seq, r_data;
    logic [15:0] r_cmd, r_len;
    logic        r_last, r_busy;
    t_phase      r_phase, n_phase;
    logic [7:0]  w_byte, w_crc8;
    logic [15:0] w_crc16;
    logic        w_emit, w_final, w_in_acc, w_hdr;
    t_crc_ctl    w_ctl;

    assign w_emit   = r_busy && (!m_axis_tvalid || m_axis_tready);
    assign w_final  = (r_phase == PH_DATA && !r_last) || r_phase == PH_CRC_HI;
    assign s_axis_tready = !r_busy || (w_emit && w_final);
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_hdr    = r_phase == PH_SOF || r_phase == PH_LEN_LO ||
                      r_phase == PH_LEN_HI || r_phase == PH_SEQ;

    always_comb begin
        w_ctl.fold16  = w_emit && r_phase != PH_CRC_LO && r_phase != PH_CRC_HI;
        w_ctl.fold8   = w_emit && w_hdr;
        w_ctl.restart = r_phase == PH_SOF;
        w_ctl.clear16 = w_emit && r_phase == PH_CRC_HI;
    end

    sfe_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_byte  (w_byte),
        .o_crc16 (w_crc16),
        .o_crc8  (w_crc8)
    );

    always_comb begin
        unique case (r_phase)
            PH_SOF:    begin w_byte = r_sof;          n_phase = PH_LEN_LO; end
            PH_LEN_LO: begin w_byte = r_len[7:0];     n_phase = PH_LEN_HI; end
            PH_LEN_HI: begin w_byte = r_len[15:8];    n_phase = PH_SEQ;    end
            PH_SEQ:    begin w_byte = r_seq;          n_phase = PH_CRC8;   end
            PH_CRC8:   begin w_byte = w_crc8;         n_phase = PH_CMD_LO; end
            PH_CMD_LO: begin w_byte = r_cmd[7:0];     n_phase = PH_CMD_HI; end
            PH_CMD_HI: begin w_byte = r_cmd[15:8];    n_phase = PH_DATA;   end
            PH_DATA:   begin w_byte = r_data;         n_phase = PH_CRC_LO; end
            PH_CRC_LO: begin w_byte = w_crc16[7:0];   n_phase = PH_CRC_HI; end
            PH_CRC_HI: begin w_byte = w_crc16[15:8];  n_phase = PH_DATA;   end
            default:   begin w_byte = r_data;         n_phase = PH_DATA;   end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sof <= SOF_RESET;
            r_cmd <= CMD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SOF: r_sof <= i_cfg_data[7:0];
                CFG_CMD: r_cmd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_data <= s_axis_tdata[7:0];
            r_len  <= s_axis_tdata[23:8];
            r_last <= s_axis_tlast;
        end
        if (w_emit) begin
            m_axis_tdata <= w_byte;
            m_axis_tlast <= w_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_phase       <= PH_DATA;
            r_seq         <= 8'd0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_busy  <= 1'b1;
                r_phase <= s_axis_tuser ? PH_SOF : PH_DATA;
            end else if (w_emit) begin
                if (w_final) begin
                    r_busy <= 1'b0;
                end
                r_phase <= n_phase;
            end
            if (w_emit && r_phase == PH_CRC_HI) begin
                r_seq <= r_seq + 8'd1;
            end
            if (w_emit) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_idle_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_final && !w_in_acc) |=> !r_busy)
        else $error("item not retired after final byte");
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_phase == PH_CRC_HI) |=> r_seq == $past(r_seq) + 8'd1)
        else $error("sequence number did not advance on trailer");
    a_hdr_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tuser) |=> (r_busy && r_phase == PH_SOF))
        else $error("first word did not start a header");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> m_axis_tvalid && m_axis_tlast == $past(w_final))
        else $error("emitted byte not presented");
`endif

endmodule

@@ rtl/sfe_crc.sv @@
// Running reflected CRC-8 (poly 0x31, init 0xFF, header) and CRC-16/MCRF4XX (frame) registers.
// Depends on sfe_pkg.
module sfe_crc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfe_pkg::t_crc_ctl i_ctl,
    input  logic [7:0]        i_byte,
    output logic [15:0]       o_crc16,
    output logic [7:0]        o_crc8
);
    import sfe_pkg::*;

    logic [15:0] r_crc16, n_crc16;
    logic [7:0]  r_crc8, n_crc8;
    logic [15:0] w_base16;
    logic [7:0]  w_base8;

    always_comb begin
        w_base16 = i_ctl.restart ? CRC16_INIT : r_crc16;
        w_base8  = i_ctl.restart ? CRC8_INIT : r_crc8;
        if (i_ctl.clear16) begin
            n_crc16 = CRC16_INIT;
        end else if (i_ctl.fold16) begin
            n_crc16 = crc16_byte(w_base16, i_byte);
        end else begin
            n_crc16 = r_crc16;
        end
        n_crc8 = i_ctl.fold8 ? crc8_byte(w_base8, i_byte) : r_crc8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc16 <= CRC16_INIT;
            r_crc8  <= CRC8_INIT;
        end else begin
            r_crc16 <= n_crc16;
            r_crc8  <= n_crc8;
        end
    end

    assign o_crc16 = r_crc16;
    assign o_crc8  = r_crc8;

endmodule

@@ sim/serial_frame_encoder_crc8_crc16_tb.sv @@
// Testbench for serial_frame_encoder_crc8_crc16: a directed table followed by
// random frames under several configurations, scored against an in-bench frame encoder.
// Depends on sfe_pkg and the serial_frame_encoder_crc8_crc16 RTL.
`timescale 1ns / 100ps

module serial_frame_encoder_crc8_crc16_tb;
    import sfe_pkg::*;

    localparam int MAX_GAP     = 12;
    localparam int LONG_HOLD   = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 12;
    localparam int PHASE_WORDS = 62;
    localparam int N_DIRECTED  = 20;
    localparam int N_PHASES    = 5;

    typedef struct packed {
        logic [7:0] tx;
        logic       eof;
    } t_tx_exp;

    typedef struct packed {
        logic [7:0]  pb;
        logic        fst;
        logic        lst;
        logic [15:0] plen;
        logic [3:0]  n_want;
        logic [7:0]  head_want;
    } t_dir_row;

    typedef struct packed {
        logic [7:0]  sof;
        logic [15:0] cmd;
        logic        rnd;
        logic        src_fast;
        logic        snk_fast;
        logic        long_hold;
    } t_phase_set;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;

    // encoder state mirrored in the bench
    logic [7:0]  sof_reg;
    logic [15:0] cmd_reg;
    logic [7:0]  seq_num;
    logic [15:0] line_crc;
    t_tx_exp     tx_bytes_q[$];

    int mismatches;
    int words_sent;
    int bytes_checked;
    int frames_closed;
    int long_holds;
    bit src_no_idle;
    bit snk_no_idle;
    bit hold_long;

    // pb, first, last, length, result count, first result byte
    t_dir_row dir_tbl [N_DIRECTED] = '{
        '{8'h00, 1'b1, 1'b0, 16'h0003, 4'd8,  8'hA5},  // first frame after reset
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 4'd1,  8'hFF},
        '{8'h55, 1'b0, 1'b0, 16'hFFFF, 4'd1,  8'h55},
        '{8'h81, 1'b0, 1'b1, 16'h0000, 4'd3,  8'h81},
        '{8'hFF, 1'b1, 1'b1, 16'hFFFF, 4'd10, 8'hA5},  // one-byte frame, max length
        '{8'h00, 1'b1, 1'b1, 16'h0000, 4'd10, 8'hA5},
        '{8'h12, 1'b0, 1'b0, 16'hAAAA, 4'd1,  8'h12},  // bytes outside a frame
        '{8'h34, 1'b0, 1'b0, 16'h5555, 4'd1,  8'h34},
        '{8'h56, 1'b0, 1'b1, 16'h0000, 4'd3,  8'h56},
        '{8'h00, 1'b0, 1'b1, 16'h0000, 4'd3,  8'h00},  // trailer right after a trailer
        '{8'h7E, 1'b1, 1'b0, 16'h8001, 4'd8,  8'hA5},
        '{8'h01, 1'b0, 1'b0, 16'h0000, 4'd1,  8'h01},
        '{8'hC3, 1'b1, 1'b0, 16'h1234, 4'd8,  8'hA5},  // restart while a frame is open
        '{8'h3C, 1'b0, 1'b1, 16'h0000, 4'd3,  8'h3C},
        '{8'h80, 1'b1, 1'b0, 16'h0005, 4'd8,  8'hA5},  // fewer bytes than declared
        '{8'h08, 1'b0, 1'b1, 16'h0000, 4'd3,  8'h08},
        '{8'hAA, 1'b1, 1'b0, 16'h00FF, 4'd8,  8'hA5},
        '{8'h5A, 1'b0, 1'b0, 16'hFF00, 4'd1,  8'h5A},
        '{8'hA5, 1'b0, 1'b0, 16'h0000, 4'd1,  8'hA5},
        '{8'hFE, 1'b0, 1'b1, 16'h0000, 4'd3,  8'hFE}
    };

    t_phase_set phase_tbl [N_PHASES] = '{
        '{8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
        '{8'hFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0},
        '{8'h00, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b1},
        '{8'h00, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0},
        '{8'h00, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0}
    };

    serial_frame_encoder_crc8_crc16 DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] payload_byte, [23:8] payload_length
        .s_axis_tlast  (s_axis_tlast),   // last_byte
        .s_axis_tuser  (s_axis_tuser),   // first_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] tx_byte
        .m_axis_tlast  (m_axis_tlast)    // run_end
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // bitwise reflected CRC updates
    function automatic logic [7:0] crc8_fold(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = c;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = {1'b0, r[7:1]} ^ (fb ? CRC8_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [15:0] crc16_fold(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = {1'b0, r[15:1]} ^ (fb ? CRC16_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic int draw_gap(input bit no_idle);
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH @%0t %s: got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    // Encode one accepted word into the line bytes it produces.
    task automatic encode_word(input logic [7:0] pb, input logic fst, input logic lst,
                               input logic [15:0] plen, output int n, output logic [7:0] head);
        logic [7:0] body[$];
        t_tx_exp    pend[$];
        t_tx_exp    e;
        logic [7:0] c8;
        if (fst) begin
            body = '{sof_reg, plen[7:0], plen[15:8], seq_num};
            c8 = CRC8_INIT;
            foreach (body[i]) c8 = crc8_fold(c8, body[i]);
            body.push_back(c8);
            body.push_back(cmd_reg[7:0]);
            body.push_back(cmd_reg[15:8]);
            line_crc = CRC16_INIT;
        end
        body.push_back(pb);
        foreach (body[i]) begin
            line_crc = crc16_fold(line_crc, body[i]);
            pend.push_back('{body[i], 1'b0});
        end
        if (lst) begin
            pend.push_back('{line_crc[7:0], 1'b0});
            pend.push_back('{line_crc[15:8], 1'b0});
            seq_num  = seq_num + 8'd1;
            line_crc = CRC16_INIT;
            frames_closed++;
        end
        e = pend.pop_back();
        e.eof = 1'b1;
        pend.push_back(e);
        n    = pend.size();
        head = pend[0].tx;
        foreach (pend[i]) tx_bytes_q.push_back(pend[i]);
    endtask

    task automatic send_word(input logic [7:0] pb, input logic fst, input logic lst,
                             input logic [15:0] plen, output int n, output logic [7:0] head);
        int gap;
        gap = draw_gap(src_no_idle);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {plen, pb};
        s_axis_tlast  = lst;
        s_axis_tuser  = fst;
        do @(posedge i_clk); while (!s_axis_tready);
        encode_word(pb, fst, lst, plen, n, head);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (tx_bytes_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        if (idx == CFG_SOF) sof_reg = val[7:0];
        else                cmd_reg = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // One random burst: mostly well-formed frames, some stray or abandoned ones.
    task automatic send_burst();
        int         pick;
        int         nbytes;
        int         n;
        logic [7:0] head;
        logic [15:0] dlen;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            nbytes = ($urandom_range(0, 99) < 50) ? 1 : $urandom_range(2, 5);
            case ($urandom_range(0, 3))
                0:       dlen = 16'(nbytes);
                1:       dlen = 16'($urandom);
                2:       dlen = 16'hFFFF;
                default: dlen = 16'($urandom_range(0, 8));
            endcase
            for (int i = 0; i < nbytes; i++)
                send_word(8'($urandom), i == 0, i == nbytes - 1,
                          (i == 0) ? dlen : 16'($urandom), n, head);
        end else if (pick < 93) begin
            send_word(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 16'($urandom), n, head);
        end else begin
            send_word(8'($urandom), 1'b1, 1'b0, 16'($urandom), n, head);
            send_word(8'($urandom), 1'b0, 1'b0, 16'($urandom), n, head);
        end
    endtask

    // output side: per-byte stall, with a long hold-off in a phase that asks for one
    initial begin : sink
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_long) begin
                gap       = LONG_HOLD;
                hold_long = 1'b0;
                long_holds++;
            end else begin
                gap = draw_gap(snk_no_idle);
            end
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : line_check
        t_tx_exp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tx_bytes_q.size() == 0) begin
                report_mismatch("byte with nothing pending", m_axis_tdata, 0);
            end else begin
                want = tx_bytes_q.pop_front();
                bytes_checked++;
                if (m_axis_tdata != want.tx)
                    report_mismatch("tx_byte", m_axis_tdata, want.tx);
                if (m_axis_tlast != want.eof)
                    report_mismatch("run_end", m_axis_tlast, want.eof);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("serial_frame_encoder_crc8_crc16 regression: fail");
        $finish;
    end

    initial begin : stim
        int          n;
        int          start_words;
        logic [7:0]  head;
        logic [7:0]  sof_v;
        logic [15:0] cmd_v;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_SOF;
        i_cfg_data    = 16'h0000;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 24'h0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        sof_reg       = SOF_RESET;
        cmd_reg       = CMD_RESET;
        seq_num       = 8'h00;
        line_crc      = CRC16_INIT;
        mismatches    = 0;
        words_sent    = 0;
        bytes_checked = 0;
        frames_closed = 0;
        long_holds    = 0;
        src_no_idle   = 1'b0;
        snk_no_idle   = 1'b0;
        hold_long     = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_word(dir_tbl[r].pb, dir_tbl[r].fst, dir_tbl[r].lst, dir_tbl[r].plen, n, head);
            if (n != int'(dir_tbl[r].n_want))
                report_mismatch($sformatf("row %0d byte count", r), n, dir_tbl[r].n_want);
            if (head != dir_tbl[r].head_want)
                report_mismatch($sformatf("row %0d first byte", r), head, dir_tbl[r].head_want);
        end
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            sof_v = phase_tbl[p].rnd ? 8'($urandom) : phase_tbl[p].sof;
            cmd_v = phase_tbl[p].rnd ? 16'($urandom) : phase_tbl[p].cmd;
            cfg_write(CFG_SOF, {8'h00, sof_v});
            cfg_write(CFG_CMD, cmd_v);
            src_no_idle = phase_tbl[p].src_fast;
            snk_no_idle = phase_tbl[p].snk_fast;
            if (phase_tbl[p].long_hold) begin
                src_no_idle = 1'b1;
                hold_long   = 1'b1;
            end
            start_words = words_sent;
            while (words_sent - start_words < PHASE_WORDS) send_burst();
            wait_drained();
        end

        $display("covered %0d input words, %0d line bytes, %0d closed frames", words_sent,
                 bytes_checked, frames_closed);
        $display("over %0d register settings and %0d long output hold-offs", N_PHASES + 1,
                 long_holds);
        if (mismatches == 0)
            $display("serial_frame_encoder_crc8_crc16 regression: pass");
        else
            $display("serial_frame_encoder_crc8_crc16 regression: fail");
        $finish;
    end

endmodule
